// File: rtl/core/comb_sort_engine_defines.svh
// ----------------------------------------------------------------------------
// Comb sort engine assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during rst.
// ----------------------------------------------------------------------------
`ifndef COMB_SORT_ENGINE_DEFINES_SVH
`define COMB_SORT_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define CSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cse_pkg.sv
// ----------------------------------------------------------------------------
// Comb sort engine package
// Beat types, controller/datapath command and status groups, sizing.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 64;
  localparam int CNT_W    = 16;

  // floor(g * 1000 / 1247) as (g * SHRINK_MUL) >> SHRINK_SHIFT, exact for
  // every g below 128
  localparam int SHRINK_SHIFT = 16;
  localparam logic [SHRINK_SHIFT-1:0] SHRINK_MUL = 16'd52555;
  localparam int PROD_W = COUNT_W + SHRINK_SHIFT;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
  } cse_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic [CNT_W-1:0]          compare_count;
    logic [CNT_W-1:0]          swap_count;
    logic                      overflow;
  } cse_out_t;

  typedef struct packed {
    logic load;       // store the accepted beat
    logic init;       // gap := count, mark pass needed
    logic shrink;     // gap := shrunk gap, rewind scan
    logic read_pair;  // read elements i and i+gap
    logic compare;    // count one comparison
    logic swap_a;     // write upper element at i
    logic swap_b;     // write lower element at i+gap
    logic advance;    // step scan index
    logic rewind;     // scan index := 0
    logic emit;       // read element i for output
    logic clear;      // end of set: drop count and counters
  } cse_cmd_t;

  typedef struct packed {
    logic scan_more;  // i + gap < count
    logic pass_more;  // gap > 1 or a swap seen in this pass
    logic greater;    // element i above element i+gap
    logic emit_end;   // i is the final element
  } cse_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// File: rtl/core/cse_ctrl.sv
// ----------------------------------------------------------------------------
// Comb sort engine controller
// Sequences load, shrink, scan, compare, swap and emit over the datapath.
// ----------------------------------------------------------------------------
`include "comb_sort_engine_defines.svh"

module cse_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last_in,
  input  cse_pkg::cse_status_t status,
  output cse_pkg::cse_cmd_t    cmd,
  output logic                 busy
);
  import cse_pkg::*;

  typedef enum logic [3:0] {
    IDLE, INIT, SHRINK, SCAN, CMP, WR_A, WR_B, EMIT, FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_in) state_next = INIT;
        end
      end
      INIT: begin
        cmd.init   = 1'b1;
        state_next = SHRINK;
      end
      SHRINK: begin
        cmd.shrink = 1'b1;
        state_next = SCAN;
      end
      SCAN: begin
        if (status.scan_more) begin
          cmd.read_pair = 1'b1;
          state_next    = CMP;
        end else if (status.pass_more) begin
          state_next = SHRINK;
        end else begin
          cmd.rewind = 1'b1;
          state_next = EMIT;
        end
      end
      CMP: begin
        cmd.compare = 1'b1;
        if (status.greater) begin
          state_next = WR_A;
        end else begin
          cmd.advance = 1'b1;
          state_next  = SCAN;
        end
      end
      WR_A: begin
        cmd.swap_a = 1'b1;
        state_next = WR_B;
      end
      WR_B: begin
        cmd.swap_b  = 1'b1;
        cmd.advance = 1'b1;
        state_next  = SCAN;
      end
      EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_end) state_next = FLUSH;
      end
      FLUSH: begin
        cmd.clear  = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

  `CSE_ASSERT_NEXT(a_swap_pairs, cmd.swap_a, cmd.swap_b, "swap write left unpaired")
  `CSE_ASSERT_NEXT(a_read_then_cmp, cmd.read_pair, cmd.compare, "pair read not compared")
  `CSE_ASSERT_NEXT(a_last_busy, start && !busy && last_in, busy, "set end left block idle")

endmodule

// File: rtl/core/cse_datapath.sv
// ----------------------------------------------------------------------------
// Comb sort engine datapath
// Element store, gap and scan registers, counters and result register.
// ----------------------------------------------------------------------------
`include "comb_sort_engine_defines.svh"

module cse_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cse_pkg::cse_in_t     item,
  input  cse_pkg::cse_cmd_t    cmd,
  output cse_pkg::cse_status_t status,
  output cse_pkg::cse_out_t    result,
  output logic                 strobe
);
  import cse_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  logic signed [VALUE_W-1:0] element_store [CAPACITY];
  logic signed [VALUE_W-1:0] rd_a;
  logic signed [VALUE_W-1:0] rd_b;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] gap;
  logic [COUNT_W-1:0] idx;
  logic               swap_seen;
  logic [CNT_W-1:0]   comparisons;
  logic [CNT_W-1:0]   exchanges;
  logic               dropped;
  logic               out_last;

  logic [COUNT_W:0]   pair_sum;
  logic [ADDR_W-1:0]  addr_a;
  logic [ADDR_W-1:0]  addr_b;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic               room;
  logic [PROD_W-1:0]  shrink_prod;
  logic [COUNT_W-1:0] gap_shrunk;

  assign room     = (count < CAP_COUNT);
  assign pair_sum = {1'b0, idx} + {1'b0, gap};
  assign addr_a   = idx[ADDR_W-1:0];
  assign addr_b   = pair_sum[ADDR_W-1:0];

  assign shrink_prod = PROD_W'(gap) * PROD_W'(SHRINK_MUL);
  assign gap_shrunk  = (shrink_prod[PROD_W-1:SHRINK_SHIFT] == '0)
                       ? COUNT_W'(1) : shrink_prod[PROD_W-1:SHRINK_SHIFT];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = item.value;
    if (cmd.load && room) begin
      wr_en = 1'b1;
    end else if (cmd.swap_a) begin
      wr_en   = 1'b1;
      wr_addr = addr_a;
      wr_data = rd_b;
    end else if (cmd.swap_b) begin
      wr_en   = 1'b1;
      wr_addr = addr_b;
      wr_data = rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) element_store[wr_addr] <= wr_data;
    rd_a <= element_store[addr_a];
    rd_b <= element_store[addr_b];
  end

  assign status.scan_more = (pair_sum < {1'b0, count});
  assign status.pass_more = (gap > COUNT_W'(1)) || swap_seen;
  assign status.greater   = (rd_a > rd_b);
  assign status.emit_end  = (({1'b0, idx} + 1'b1) == {1'b0, count});

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      gap         <= '0;
      idx         <= '0;
      swap_seen   <= 1'b0;
      comparisons <= '0;
      exchanges   <= '0;
      dropped     <= 1'b0;
      strobe      <= 1'b0;
      out_last    <= 1'b0;
    end else begin
      strobe   <= cmd.emit;
      out_last <= cmd.emit && status.emit_end;
      if (cmd.load) begin
        if (room) count <= count + 1'b1;
        else      dropped <= 1'b1;
      end
      if (cmd.init) begin
        gap       <= count;
        swap_seen <= 1'b1;
      end
      if (cmd.shrink) begin
        gap       <= gap_shrunk;
        swap_seen <= 1'b0;
        idx       <= '0;
      end
      if (cmd.compare) comparisons <= sat_inc(comparisons);
      if (cmd.swap_a) begin
        exchanges <= sat_inc(exchanges);
        swap_seen <= 1'b1;
      end
      if (cmd.advance || cmd.emit) idx <= idx + 1'b1;
      if (cmd.rewind) idx <= '0;
      if (cmd.clear) begin
        count       <= '0;
        gap         <= '0;
        idx         <= '0;
        swap_seen   <= 1'b0;
        comparisons <= '0;
        exchanges   <= '0;
        dropped     <= 1'b0;
      end
    end
  end

  assign result.sorted_value  = rd_a;
  assign result.last_out      = out_last;
  assign result.compare_count = comparisons;
  assign result.swap_count    = exchanges;
  assign result.overflow      = dropped;

  `CSE_ASSERT_NOW(a_count_cap, 1'b1, count <= CAP_COUNT, "element count past capacity")
  `CSE_ASSERT_NOW(a_gap_live, cmd.read_pair, gap != '0, "pair read with zero gap")
  `CSE_ASSERT_NOW(a_emit_nonempty, strobe, count != '0, "result beat from empty set")

endmodule

// File: rtl/core/comb_sort_engine.sv
// ----------------------------------------------------------------------------
// Comb sort engine
// Collects signed 64-bit values, sorts them by comb sort, streams them out.
// ----------------------------------------------------------------------------
// Load one value per beat (start high while busy is low) until the beat
// marked last_in; up to CAPACITY (64) values are kept and any further ones
// are dropped and flagged through overflow. Busy stays low throughout loading.
// After the last beat the block goes busy and sorts: it takes the first gap
// from the count, then per pass shrinks the gap and scans the pairs; each pair
// is read from the dual-read element store, then compared, and an exchanged
// pair is written back one element at a time, as the store has a single
// write port. A closing scan step finds each pass done.
// Results then leave one per cycle in ascending order, a single-cycle beat
// on strobe, with last_out on the final one; the receiver cannot hold them
// off, so take every strobed beat. In the cycle after the final beat busy
// falls and the next set may start. Comparison and exchange counts, which
// saturate at 65535, and the overflow flag ride on every beat of the set.
// ----------------------------------------------------------------------------
module comb_sort_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cse_pkg::cse_in_t  item,
  output cse_pkg::cse_out_t result,
  output logic              strobe
);
  import cse_pkg::*;

  cse_cmd_t    cmd;
  cse_status_t status;

  // Sequencer: owns the pass and scan order, decodes commands per state.
  cse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_in (item.last_in),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Datapath: element store, gap arithmetic, counters and result beat.
  cse_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result),
    .strobe (strobe)
  );

endmodule
